[src/sat_pkg.sv]
package sat_pkg;

    // results one input byte can cause at most
    localparam int MAX_RESULTS = 4;

    // parser modes
    typedef enum logic [2:0] {
        M_LEAD = 3'd0,
        M_ARG  = 3'd1,
        M_ESC  = 3'd2,
        M_HEX  = 3'd3,
        M_OCT  = 3'd4,
        M_SEP  = 3'd5
    } t_mode;

    // open quote
    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_DOUBLE = 2'd1,
        Q_SINGLE = 2'd2
    } t_quote;

    // result word kinds
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_ARG_END = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_HEX     = 3'd1,
        ST_HEX_ZERO   = 3'd2,
        ST_NO_OCT     = 3'd3,
        ST_OCT_ZERO   = 3'd4,
        ST_UNMATCHED  = 3'd5
    } t_status;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        t_status     status;
        logic [7:0]  count;
    } t_res;

    // all results of one input byte
    typedef struct packed {
        logic [2:0]                 rcnt;
        t_res [MAX_RESULTS-1:0]     res;
    } t_bundle;

    // front to queue write
    typedef struct packed {
        logic     push;
        t_bundle  bundle;
    } t_q_wr;

endpackage

[src/sat_front.sv]
module sat_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_in_char,
    input  logic             i_in_last,
    input  logic [7:0]       i_limit,
    input  logic             i_q_full,
    output sat_pkg::t_q_wr   o_q_wr
);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;

    // working context of one parse step
    typedef struct packed {
        sat_pkg::t_mode                       mode;
        sat_pkg::t_quote                      quote;
        logic [7:0]                           eval;
        logic [2:0]                           dcnt;
        logic [7:0]                           started;
        logic                                 has;
        logic                                 stopped;
        logic [2:0]                           rcnt;
        sat_pkg::t_res [sat_pkg::MAX_RESULTS-1:0] res;
    } t_ctx;

    function automatic logic f_is_ws(input logic [7:0] ch);
        return (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    // arguments ended so far
    function automatic logic [7:0] f_done_count(input t_ctx c);
        logic [7:0] prev;
        prev = (c.started != 8'd0) ? c.started - 8'd1 : 8'd0;
        if (c.mode == sat_pkg::M_LEAD) return 8'd0;
        if (c.mode == sat_pkg::M_SEP) return c.has ? c.started : prev;
        return prev;
    endfunction

    function automatic t_ctx f_emit(input t_ctx c, input sat_pkg::t_kind k,
                                    input logic [7:0] b, input sat_pkg::t_status s);
        t_ctx r;
        r = c;
        if (c.rcnt < 3'(sat_pkg::MAX_RESULTS)) begin
            r.res[c.rcnt[1:0]].kind   = k;
            r.res[c.rcnt[1:0]].data   = b;
            r.res[c.rcnt[1:0]].status = s;
            r.res[c.rcnt[1:0]].count  = f_done_count(c);
            r.rcnt = c.rcnt + 3'd1;
        end
        return r;
    endfunction

    function automatic t_ctx f_finish(input t_ctx c, input sat_pkg::t_status s);
        t_ctx r;
        r = f_emit(c, sat_pkg::KIND_STATUS, 8'd0, s);
        r.stopped = 1'b1;
        return r;
    endfunction

    function automatic t_ctx f_literal(input t_ctx c, input logic [7:0] b);
        t_ctx r;
        r = c;
        r.has = 1'b1;
        return f_emit(r, sat_pkg::KIND_BYTE, b, sat_pkg::ST_OK);
    endfunction

    function automatic t_ctx f_start_arg(input t_ctx c, input logic [7:0] lim);
        t_ctx r;
        r = c;
        r.started = c.started + 8'd1;
        r.has     = 1'b0;
        r.quote   = sat_pkg::Q_NONE;
        r.mode    = sat_pkg::M_ARG;
        if (r.started >= lim) r = f_finish(r, sat_pkg::ST_OK);
        return r;
    endfunction

    function automatic t_ctx f_close_digits(input t_ctx c);
        t_ctx r;
        logic hex;
        r = c;
        hex = (c.mode == sat_pkg::M_HEX);
        if (c.dcnt == 3'd0) begin
            r = f_finish(c, hex ? sat_pkg::ST_NO_HEX : sat_pkg::ST_NO_OCT);
        end else if (c.eval == 8'd0) begin
            r = f_finish(c, hex ? sat_pkg::ST_HEX_ZERO : sat_pkg::ST_OCT_ZERO);
        end else begin
            r.mode = sat_pkg::M_ARG;
            r = f_literal(r, c.eval);
        end
        return r;
    endfunction

    function automatic t_ctx f_arg_char(input t_ctx c, input logic [7:0] ch);
        t_ctx r;
        sat_pkg::t_quote q;
        r = c;
        q = (ch == CH_DQUOTE) ? sat_pkg::Q_DOUBLE :
            ((ch == CH_SQUOTE) ? sat_pkg::Q_SINGLE : sat_pkg::Q_NONE);
        if (ch == CH_BACKSLASH) begin
            r.mode = sat_pkg::M_ESC;
        end else if (f_is_ws(ch) && c.quote == sat_pkg::Q_NONE) begin
            r.mode = sat_pkg::M_SEP;
            if (c.has) r = f_emit(r, sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
        end else if (q != sat_pkg::Q_NONE) begin
            if (c.quote == sat_pkg::Q_NONE) r.quote = q;
            else if (c.quote == q) r.quote = sat_pkg::Q_NONE;
            else r = f_literal(c, ch);
        end else begin
            r = f_literal(c, ch);
        end
        return r;
    endfunction

    // {valid, value} of a hex or octal digit
    function automatic logic [4:0] f_digit(input logic [7:0] ch, input logic hex);
        logic [7:0] v;
        v = 8'd0;
        if (ch >= 8'h30 && ch <= 8'h37) begin
            v = ch - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (!hex) return 5'd0;
        if (ch == 8'h38 || ch == 8'h39) begin
            v = ch - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (ch >= 8'h61 && ch <= 8'h66) begin
            v = ch - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (ch >= 8'h41 && ch <= 8'h46) begin
            v = ch - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic t_ctx f_process(input t_ctx c, input logic [7:0] ch,
                                       input logic [7:0] lim);
        t_ctx r;
        logic hex;
        logic [4:0] d;
        r = c;
        hex = (c.mode == sat_pkg::M_HEX);
        d = f_digit(ch, hex);
        unique case (c.mode)
            sat_pkg::M_LEAD: begin
                if (!f_is_ws(ch)) begin
                    r = f_start_arg(r, lim);
                    if (!r.stopped) r = f_arg_char(r, ch);
                end
            end
            sat_pkg::M_SEP: begin
                if (!f_is_ws(ch)) begin
                    if (!r.has) begin
                        r.has = 1'b1;
                        r = f_emit(r, sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
                    end
                    r = f_start_arg(r, lim);
                    if (!r.stopped) r = f_arg_char(r, ch);
                end
            end
            sat_pkg::M_ESC: begin
                if (ch == CH_N) begin
                    r.mode = sat_pkg::M_ARG;
                    r = f_literal(r, CH_LF);
                end else if (ch == CH_R) begin
                    r.mode = sat_pkg::M_ARG;
                    r = f_literal(r, CH_CR);
                end else if (ch == CH_ZERO || ch == CH_X) begin
                    r.mode = (ch == CH_X) ? sat_pkg::M_HEX : sat_pkg::M_OCT;
                    r.eval = 8'd0;
                    r.dcnt = 3'd0;
                end else begin
                    r.mode = sat_pkg::M_ARG;
                    r = f_literal(r, ch);
                end
            end
            sat_pkg::M_HEX, sat_pkg::M_OCT: begin
                if (!d[4]) begin
                    r = f_close_digits(r);
                    if (!r.stopped) r = f_arg_char(r, ch);
                end else begin
                    r.eval = hex ? {c.eval[3:0], d[3:0]} : {c.eval[4:0], d[2:0]};
                    r.dcnt = c.dcnt + 3'd1;
                    if (r.dcnt >= (hex ? 3'd2 : 3'd4)) r = f_close_digits(r);
                end
            end
            sat_pkg::M_ARG: begin
                r = f_arg_char(r, ch);
            end
            default: begin
                r.mode = sat_pkg::M_ARG;
                r = f_arg_char(r, ch);
            end
        endcase
        return r;
    endfunction

    function automatic t_ctx f_end_line(input t_ctx c);
        t_ctx r;
        r = c;
        if (r.mode == sat_pkg::M_HEX || r.mode == sat_pkg::M_OCT) begin
            r = f_close_digits(r);
            if (r.stopped) return r;
        end
        if (r.mode == sat_pkg::M_ESC) r.mode = sat_pkg::M_ARG;
        if (r.mode == sat_pkg::M_ARG) begin
            if (r.quote != sat_pkg::Q_NONE) return f_finish(r, sat_pkg::ST_UNMATCHED);
            r.mode = sat_pkg::M_SEP;
            if (r.has) r = f_emit(r, sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
        end
        return f_finish(r, sat_pkg::ST_OK);
    endfunction

    sat_pkg::t_mode   r_mode,     n_mode;
    sat_pkg::t_quote  r_quote,    n_quote;
    logic [7:0]       r_eval,     n_eval;
    logic [2:0]       r_dcnt,     n_dcnt;
    logic [7:0]       r_started,  n_started;
    logic             r_has,      n_has;
    logic             r_finished, n_finished;

    logic  s_accept;
    logic  s_ending;
    t_ctx  s_cur;
    t_ctx  s_run;

    assign s_accept = i_valid && !o_stall;
    assign s_ending = (i_in_char == 8'd0) || i_in_last;

    // one parse step over the current word
    always_comb begin
        s_cur         = '0;
        s_cur.mode    = r_mode;
        s_cur.quote   = r_quote;
        s_cur.eval    = r_eval;
        s_cur.dcnt    = r_dcnt;
        s_cur.started = r_started;
        s_cur.has     = r_has;
        s_run = s_cur;
        if (i_in_char != 8'd0) s_run = f_process(s_run, i_in_char, i_limit);
        if (!s_run.stopped && s_ending) s_run = f_end_line(s_run);
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_quote    = r_quote;
        n_eval     = r_eval;
        n_dcnt     = r_dcnt;
        n_started  = r_started;
        n_has      = r_has;
        n_finished = r_finished;
        if (s_accept) begin
            if ((r_finished || s_run.stopped) && s_ending) begin
                n_mode     = sat_pkg::M_LEAD;
                n_quote    = sat_pkg::Q_NONE;
                n_eval     = 8'd0;
                n_dcnt     = 3'd0;
                n_started  = 8'd0;
                n_has      = 1'b0;
                n_finished = 1'b0;
            end else if (!r_finished) begin
                n_mode     = s_run.mode;
                n_quote    = s_run.quote;
                n_eval     = s_run.eval;
                n_dcnt     = s_run.dcnt;
                n_started  = s_run.started;
                n_has      = s_run.has;
                n_finished = s_run.stopped;
            end
        end
    end

    // queue write and input stall
    always_comb begin
        o_stall              = i_q_full;
        o_q_wr.push          = s_accept && !r_finished && (s_run.rcnt != 3'd0);
        o_q_wr.bundle.rcnt   = s_run.rcnt;
        o_q_wr.bundle.res    = s_run.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sat_pkg::M_LEAD;
            r_quote    <= sat_pkg::Q_NONE;
            r_eval     <= 8'd0;
            r_dcnt     <= 3'd0;
            r_started  <= 8'd0;
            r_has      <= 1'b0;
            r_finished <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_quote    <= n_quote;
            r_eval     <= n_eval;
            r_dcnt     <= n_dcnt;
            r_started  <= n_started;
            r_has      <= n_has;
            r_finished <= n_finished;
        end
    end

endmodule

[src/sat_queue.sv]
module sat_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sat_pkg::t_q_wr    i_q_wr,
    output logic              o_full,
    input  logic              i_pop,
    output sat_pkg::t_bundle  o_head,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sat_pkg::t_bundle  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_q_wr.push) n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
        if (i_pop)       n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
        if (i_q_wr.push && !i_pop)      n_cnt = r_cnt + CNT_W'(1);
        else if (!i_q_wr.push && i_pop) n_cnt = r_cnt - CNT_W'(1);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) r_mem[r_wptr] <= i_q_wr.bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[src/sat_back.sv]
module sat_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sat_pkg::t_bundle  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_out_byte,
    output logic [2:0]        o_status,
    output logic [7:0]        o_arg_count,
    output logic              o_run_end
);

    logic              r_valid,   n_valid;
    sat_pkg::t_res     r_out,     n_out;
    logic              r_run_end, n_run_end;
    sat_pkg::t_bundle  r_buf,     n_buf;
    logic [1:0]        r_idx,     n_idx;
    logic              r_have,    n_have;

    logic s_load;
    logic s_last;

    assign s_load = !r_valid || !i_stall;
    assign s_last = ({1'b0, r_idx} == (r_buf.rcnt - 3'd1));

    // next result word into the output register
    always_comb begin
        n_valid   = r_valid;
        n_out     = r_out;
        n_run_end = r_run_end;
        n_buf     = r_buf;
        n_idx     = r_idx;
        n_have    = r_have;
        o_pop     = 1'b0;
        if (s_load) begin
            if (r_have) begin
                n_valid   = 1'b1;
                n_out     = r_buf.res[r_idx];
                n_run_end = s_last;
                if (s_last) n_have = 1'b0;
                else        n_idx  = r_idx + 2'd1;
            end else if (!i_empty) begin
                o_pop     = 1'b1;
                n_valid   = 1'b1;
                n_out     = i_head.res[0];
                n_run_end = (i_head.rcnt == 3'd1);
                if (i_head.rcnt != 3'd1) begin
                    n_buf  = i_head;
                    n_idx  = 2'd1;
                    n_have = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_out.kind;
    assign o_out_byte  = r_out.data;
    assign o_status    = r_out.status;
    assign o_arg_count = r_out.count;
    assign o_run_end   = r_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_have  <= n_have;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_run_end <= n_run_end;
        r_buf     <= n_buf;
        r_idx     <= n_idx;
    end

endmodule

[src/shell_argument_tokenizer_unit.sv]
// shell argument tokenizer
// input channel: one command line byte per word (i_in_char, i_in_last), moved when
//   i_valid is high and o_stall is low; a zero byte or i_in_last ends the line
// output channel: result words (o_kind, o_out_byte, o_status, o_arg_count,
//   o_run_end), moved when o_valid is high and i_stall is low; o_run_end marks
//   the last word caused by one input byte, bytes that cause none give no word
// config: apb register arg_limit at address 0, pready always high, reset value 16
// path: the results of a byte are written into the queue when the byte is taken,
//   then loaded into the output register, which drives o_valid
// throughput: one byte per cycle while o_stall is low; the parser finishes a byte in
//   its cycle and the output stage sends one word per cycle while i_stall is low;
//   a queue of QUEUE_DEPTH byte results sits between the two and o_stall rises
//   only while that queue is full
// receiver stall: the output word holds, the queue fills, then o_stall rises
// reset: synchronous, active low; clears parser state, queue and output valid and
//   sets arg_limit to 16
module shell_argument_tokenizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_arg_count,
    output logic        o_run_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        r_arg_limit, n_arg_limit;
    logic [7:0]        s_limit;
    sat_pkg::t_q_wr    s_q_wr;
    logic              s_q_full;
    logic              s_q_pop;
    logic              s_q_empty;
    sat_pkg::t_bundle  s_q_head;

    // config register
    always_comb begin
        n_arg_limit = r_arg_limit;
        if (psel && penable && pwrite && pready && !paddr[2]) n_arg_limit = pwdata[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_arg_limit <= 8'd16;
        else          r_arg_limit <= n_arg_limit;
    end

    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : {24'd0, r_arg_limit};
    // a zero limit acts as one
    assign s_limit = (r_arg_limit == 8'd0) ? 8'd1 : r_arg_limit;

    sat_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_char (i_in_char),
        .i_in_last (i_in_last),
        .i_limit   (s_limit),
        .i_q_full  (s_q_full),
        .o_q_wr    (s_q_wr)
    );

    sat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (s_q_wr),
        .o_full  (s_q_full),
        .i_pop   (s_q_pop),
        .o_head  (s_q_head),
        .o_empty (s_q_empty)
    );

    sat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (s_q_head),
        .i_empty     (s_q_empty),
        .o_pop       (s_q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_arg_count (o_arg_count),
        .o_run_end   (o_run_end)
    );

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_wr.push |-> !s_q_full)
        else $error("queue written while full");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == sat_pkg::KIND_STATUS) |-> o_run_end)
        else $error("status word not last of its run");

    a_byte_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == sat_pkg::KIND_BYTE) |-> (o_status == sat_pkg::ST_OK))
        else $error("byte word with nonzero status");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_GAP       = 16;
    localparam int PHASE_BYTES   = 14;

    localparam logic [2:0] ADDR_ARG_LIMIT = 3'd0;
    localparam logic [7:0] LIMIT_AT_RESET = 8'd16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;

    // one expected result word
    typedef struct packed {
        sat_pkg::t_kind    kind;
        logic [7:0]        data;
        sat_pkg::t_status  status;
        logic [7:0]        count;
        logic              run_end;
    } t_word;

    // tokenizer predictor and expected word store
    class t_token_board;
        logic [7:0]       limit;
        sat_pkg::t_mode   mode;
        sat_pkg::t_quote  quote;
        logic [7:0]       acc;
        logic [2:0]       ndig;
        logic [7:0]       started;
        logic             has_text;
        logic             halted;
        logic             stopped;
        t_word            step_q[$];
        t_word            pending[$];
        int               errors;
        int               checked;

        function new();
            limit   = LIMIT_AT_RESET;
            errors  = 0;
            checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode     = sat_pkg::M_LEAD;
            quote    = sat_pkg::Q_NONE;
            acc      = 8'd0;
            ndig     = 3'd0;
            started  = 8'd0;
            has_text = 1'b0;
            halted   = 1'b0;
        endfunction

        function bit is_space(logic [7:0] c);
            return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // arguments finished so far
        function logic [7:0] args_done();
            if (mode == sat_pkg::M_LEAD)
                return 8'd0;
            if (mode == sat_pkg::M_SEP && has_text)
                return started;
            return (started != 8'd0) ? started - 8'd1 : 8'd0;
        endfunction

        function void push_word(sat_pkg::t_kind k, logic [7:0] d, sat_pkg::t_status s);
            t_word w;
            if (step_q.size() >= sat_pkg::MAX_RESULTS)
                return;
            w.kind    = k;
            w.data    = d;
            w.status  = s;
            w.count   = args_done();
            w.run_end = 1'b0;
            step_q.push_back(w);
        endfunction

        function void stop_line(sat_pkg::t_status s);
            push_word(sat_pkg::KIND_STATUS, 8'd0, s);
            stopped = 1'b1;
        endfunction

        function void put_char(logic [7:0] b);
            has_text = 1'b1;
            push_word(sat_pkg::KIND_BYTE, b, sat_pkg::ST_OK);
        endfunction

        // new argument slot, status once the limit is reached
        function bit open_arg();
            logic [7:0] lim;
            lim      = (limit != 8'd0) ? limit : 8'd1;
            started  = started + 8'd1;
            has_text = 1'b0;
            quote    = sat_pkg::Q_NONE;
            mode     = sat_pkg::M_ARG;
            if (started >= lim) begin
                stop_line(sat_pkg::ST_OK);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // end of a hex or octal digit run
        function bit close_run();
            bit hex;
            hex = (mode == sat_pkg::M_HEX);
            if (ndig == 3'd0) begin
                stop_line(hex ? sat_pkg::ST_NO_HEX : sat_pkg::ST_NO_OCT);
                return 1'b0;
            end
            if (acc == 8'd0) begin
                stop_line(hex ? sat_pkg::ST_HEX_ZERO : sat_pkg::ST_OCT_ZERO);
                return 1'b0;
            end
            mode = sat_pkg::M_ARG;
            put_char(acc);
            return 1'b1;
        endfunction

        function void arg_byte(logic [7:0] c);
            sat_pkg::t_quote q;
            q = (c == CH_DQUOTE) ? sat_pkg::Q_DOUBLE :
                ((c == CH_SQUOTE) ? sat_pkg::Q_SINGLE : sat_pkg::Q_NONE);
            if (c == CH_BSLASH) begin
                mode = sat_pkg::M_ESC;
            end else if (is_space(c) && quote == sat_pkg::Q_NONE) begin
                mode = sat_pkg::M_SEP;
                if (has_text)
                    push_word(sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
            end else if (q != sat_pkg::Q_NONE) begin
                if (quote == sat_pkg::Q_NONE)
                    quote = q;
                else if (quote == q)
                    quote = sat_pkg::Q_NONE;
                else
                    put_char(c);
            end else begin
                put_char(c);
            end
        endfunction

        function int digit_of(logic [7:0] c, bit hex);
            if (c >= "0" && c <= "7")
                return int'(c) - int'("0");
            if (!hex)
                return -1;
            if (c == "8" || c == "9")
                return int'(c) - int'("0");
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void eat(logic [7:0] c);
            int d;
            bit hex;
            case (mode)
                sat_pkg::M_LEAD: begin
                    if (!is_space(c)) begin
                        if (open_arg())
                            arg_byte(c);
                    end
                end
                sat_pkg::M_SEP: begin
                    if (!is_space(c)) begin
                        // empty argument before this one is kept
                        if (!has_text) begin
                            has_text = 1'b1;
                            push_word(sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
                        end
                        if (open_arg())
                            arg_byte(c);
                    end
                end
                sat_pkg::M_ESC: begin
                    if (c == CH_N) begin
                        mode = sat_pkg::M_ARG;
                        put_char(CH_LF);
                    end else if (c == CH_R) begin
                        mode = sat_pkg::M_ARG;
                        put_char(CH_CR);
                    end else if (c == CH_ZERO || c == CH_X) begin
                        mode = (c == CH_X) ? sat_pkg::M_HEX : sat_pkg::M_OCT;
                        acc  = 8'd0;
                        ndig = 3'd0;
                    end else begin
                        mode = sat_pkg::M_ARG;
                        put_char(c);
                    end
                end
                sat_pkg::M_HEX, sat_pkg::M_OCT: begin
                    hex = (mode == sat_pkg::M_HEX);
                    d   = digit_of(c, hex);
                    if (d < 0) begin
                        // run ends, byte then parsed as usual
                        if (close_run())
                            arg_byte(c);
                    end else begin
                        acc  = hex ? {acc[3:0], d[3:0]} : {acc[4:0], d[2:0]};
                        ndig = ndig + 3'd1;
                        if (ndig >= (hex ? 3'd2 : 3'd4))
                            void'(close_run());
                    end
                end
                sat_pkg::M_ARG: begin
                    arg_byte(c);
                end
                default: begin
                    mode = sat_pkg::M_ARG;
                    arg_byte(c);
                end
            endcase
        endfunction

        function void end_of_line();
            if (mode == sat_pkg::M_HEX || mode == sat_pkg::M_OCT) begin
                if (!close_run())
                    return;
            end
            // trailing backslash is dropped
            if (mode == sat_pkg::M_ESC)
                mode = sat_pkg::M_ARG;
            if (mode == sat_pkg::M_ARG) begin
                if (quote != sat_pkg::Q_NONE) begin
                    stop_line(sat_pkg::ST_UNMATCHED);
                    return;
                end
                mode = sat_pkg::M_SEP;
                if (has_text)
                    push_word(sat_pkg::KIND_ARG_END, 8'd0, sat_pkg::ST_OK);
            end
            stop_line(sat_pkg::ST_OK);
        endfunction

        // accepted input word
        function void note_byte(logic [7:0] c, logic fin);
            bit ending;
            ending = (c == CH_NUL) || fin;
            step_q.delete();
            stopped = 1'b0;
            if (halted) begin
                if (ending)
                    clear_line();
                return;
            end
            if (c != CH_NUL)
                eat(c);
            if (!stopped && ending)
                end_of_line();
            if (stopped) begin
                if (ending)
                    clear_line();
                else
                    halted = 1'b1;
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].run_end = 1'b1;
            foreach (step_q[i])
                pending.push_back(step_q[i]);
        endfunction

        function void cmp(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // accepted output word against the oldest expectation
        function void check_word(logic [1:0] kind, logic [7:0] data, logic [2:0] status,
                                 logic [7:0] count, logic run_end);
            t_word w;
            checked++;
            if (pending.size() == 0) begin
                $error("word with none expected: kind %0d byte %0h", kind, data);
                errors++;
                return;
            end
            w = pending.pop_front();
            cmp("kind", 8'(w.kind), 8'(kind));
            cmp("out_byte", w.data, data);
            cmp("status", 8'(w.status), 8'(status));
            cmp("arg_count", w.count, count);
            cmp("run_end", 8'(w.run_end), 8'(run_end));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_char;
    logic        i_in_last;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_arg_count;
    logic        o_run_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_token_board board = new();
    int tx_pace;
    int rx_pace;
    int sent;
    int cycles = 0;
    int limit_plan [7] = '{255, 1, 0, 2, 3, 5, 16};

    shell_argument_tokenizer_unit uut (.*);

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // idle cycles before a word: none, occasional or heavy
    function automatic int pick_gap(int pace);
        case (pace)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_GAP)) : 0;
            default: return int'($urandom_range(0, MAX_GAP));
        endcase
    endfunction

    function automatic logic [7:0] space_char();
        int n;
        n = $urandom_range(8, 13);
        return (n == 8) ? CH_SPACE : 8'(n);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return 8'(int'("0") + v);
        return 8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + v - 10);
    endfunction

    task automatic send_byte(logic [7:0] c, logic fin);
        int gap;
        gap = pick_gap(tx_pace);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_char <= c;
        i_in_last <= fin;
        do @(posedge i_clk); while (o_stall);
        board.note_byte(c, fin);
        sent++;
    endtask

    task automatic send_text(string s, logic mark_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], mark_last && (i == s.len() - 1));
    endtask

    // random command line, mostly well formed
    task automatic send_random_line();
        logic [7:0] text[$];
        logic [7:0] q;
        int nd;
        if ($urandom_range(0, 2) == 0)
            text.push_back(space_char());
        repeat ($urandom_range(1, 6)) begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
                end
                4: text.push_back(8'($urandom_range(8'h21, 8'h7E)));
                5, 6, 14: begin
                    repeat ($urandom_range(1, 2)) text.push_back(space_char());
                end
                7: begin
                    text.push_back(q);
                    repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    text.push_back(q);
                end
                8: begin
                    text.push_back(CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0:       text.push_back(CH_N);
                        1:       text.push_back(CH_R);
                        2:       text.push_back(8'($urandom_range(1, 255)));
                        default: text.push_back(q);
                    endcase
                end
                9: begin
                    text.push_back(CH_BSLASH);
                    text.push_back(CH_X);
                    nd = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 2));
                    repeat (nd) text.push_back(hex_char($urandom_range(0, 15)));
                end
                10: begin
                    text.push_back(CH_BSLASH);
                    text.push_back(CH_ZERO);
                    nd = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 4));
                    repeat (nd) text.push_back(8'(int'("0") + $urandom_range(0, 7)));
                end
                11: begin
                    text.push_back(q);
                    text.push_back(q);
                end
                12: text.push_back(8'($urandom_range(1, 255)));
                13: text.push_back(q);
                default: begin
                    text.push_back(CH_BSLASH);
                    text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_BSLASH);
                end
            endcase
        end
        // end the line by a zero byte or by the last flag
        if ($urandom_range(0, 3) == 0) begin
            foreach (text[i])
                send_byte(text[i], 1'b0);
            send_byte(CH_NUL, 1'($urandom_range(0, 1)));
        end else begin
            foreach (text[i])
                send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic write_limit(logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ARG_LIMIT;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.limit = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain all expected words, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side
    initial begin
        int gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = pick_gap(rx_pace);
            @(negedge i_clk);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            board.check_word(o_kind, o_out_byte, o_status, o_arg_count, o_run_end);
        end
    end

    // input side and phases
    initial begin
        int goal;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_char = 8'd0;
        i_in_last = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 3'd0;
        pwdata    = 32'd0;
        tx_pace   = 1;
        rx_pace   = 1;
        sent      = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty line
        send_text(" ", 1'b1);
        // empty argument, short hex run, octal run, escapes, top byte, trailing backslash
        send_text("'' \\x4g\\01\\r", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_NUL, 1'b0);
        // each error status
        send_text("\\xq", 1'b1);
        send_text("\\x0", 1'b1);
        send_text("\\0", 1'b1);
        send_text("\\00", 1'b1);
        send_text("\"", 1'b1);
        settle();

        foreach (limit_plan[i]) begin
            write_limit(8'(limit_plan[i]));
            tx_pace = $urandom_range(0, 2);
            rx_pace = $urandom_range(0, 2);
            // slot limit hit on the first argument
            if (limit_plan[i] <= 1)
                send_text("a b", 1'b1);
            goal = sent + PHASE_BYTES;
            while (sent < goal)
                send_random_line();
            settle();
        end

        $display("run covered %0d input bytes and %0d result words over %0d limit settings",
                 sent, board.checked, $size(limit_plan) + 1);
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[sim.f]
src/sat_pkg.sv
src/sat_front.sv
src/sat_queue.sv
src/sat_back.sv
src/shell_argument_tokenizer_unit.sv
test/tb.sv
